>>> src/sphere_pair_overlap_contacts_unit_assert.svh
// Assertion macros for the sphere pair overlap contacts unit.
// Used by the top level; expects clk and arst_n in scope.
`ifndef SPHERE_PAIR_OVERLAP_CONTACTS_UNIT_ASSERT_SVH
`define SPHERE_PAIR_OVERLAP_CONTACTS_UNIT_ASSERT_SVH

// Check a condition at every clock edge outside reset
`define SPOC_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Check that a trigger implies a condition in the same cycle
`define SPOC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

>>> src/spoc_pkg.sv
// Shared types and constants of the sphere pair overlap contacts unit.
// No dependencies.
package spoc_pkg;

	localparam int RESULT_LIMIT = 28;
	localparam int CNT_W        = 5;
	localparam int ENTRY_W      = 143;
	localparam logic [14:0] NORM_ONE = 15'd16384;

	// One sphere pair handed from the front to the back
	typedef struct packed {
		logic        has_pair;
		logic        last;
		logic [2:0]  ia;
		logic [2:0]  ib;
		logic [32:0] mag_x;
		logic [32:0] mag_y;
		logic [32:0] mag_z;
		logic        neg_x;
		logic        neg_y;
		logic        neg_z;
		logic [31:0] rsum;
		logic [15:0] rest;
	} pair_rec_t;

	typedef struct packed {
		logic [2:0]  ia;
		logic [2:0]  ib;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
		logic [30:0] depth;
		logic [15:0] rest;
	} contact_t;

	typedef enum logic [2:0] {
		F_LOAD, F_RDA, F_RDB, F_PAIR, F_END
	} front_state_t;

	typedef enum logic [3:0] {
		B_IDLE, B_MUL, B_CMP, B_SQM, B_SQD, B_DIV, B_PUSH, B_LIMIT, B_NEXT, B_FIN
	} back_state_t;

endpackage

>>> src/spoc_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module spoc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> src/spoc_fifo.sv
// Two entry queue of pair records between the front and the back.
// Depends on spoc_pkg.
module spoc_fifo import spoc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  pair_rec_t din,
	output logic      full,
	input  logic      pop,
	output pair_rec_t dout,
	output logic      empty
);

	pair_rec_t  mem_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign dout  = mem_q[rp_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= din;
		end
	end

endmodule

>>> src/spoc_front.sv
// Front: loads spheres into the store and walks pairs into the queue.
// Depends on spoc_pkg; drives the store RAM and the pair queue.
module spoc_front import spoc_pkg::*; #(
	parameter int MAX_PARTICLES = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [31:0]                      pos_x,
	input  logic [31:0]                      pos_y,
	input  logic [31:0]                      pos_z,
	input  logic [30:0]                      sphere_radius,
	input  logic [15:0]                      particle_restitution,
	input  logic                             last_particle,
	output logic                             ram_we,
	output logic [$clog2(MAX_PARTICLES)-1:0] ram_waddr,
	output logic [ENTRY_W-1:0]               ram_wdata,
	output logic [$clog2(MAX_PARTICLES)-1:0] ram_raddr,
	input  logic [ENTRY_W-1:0]               ram_rdata,
	output logic                             rec_push,
	output pair_rec_t                        rec,
	input  logic                             rec_full
);

	localparam int IW = $clog2(MAX_PARTICLES);
	localparam int CW = $clog2(MAX_PARTICLES + 1);

	front_state_t      state_q, state_d;
	logic [CW-1:0]     cnt_q, n_q, cnt_next;
	logic [IW-1:0]     i_q, h_q;
	logic [ENTRY_W-1:0] a_q;
	logic              accept, room, last_pair, h_end;
	logic [IW+2:0]     i_ext, h_ext;
	logic signed [32:0] dx, dy, dz;
	logic [30:0]       rad_a, rad_b;
	logic [15:0]       rst_a, rst_b;

	assign in_stall = state_q != F_LOAD;
	assign accept   = in_valid && !in_stall;
	assign room     = cnt_q < CW'(MAX_PARTICLES);
	assign cnt_next = room ? cnt_q + 1'b1 : cnt_q;

	assign ram_we    = accept && room;
	assign ram_waddr = cnt_q[IW-1:0];
	assign ram_wdata = {particle_restitution, sphere_radius, pos_z, pos_y, pos_x};
	assign ram_raddr = (state_q == F_RDA) ? i_q : h_q;

	assign h_end     = CW'(h_q) == n_q - 1'b1;
	assign last_pair = h_end && (CW'(i_q) == n_q - 2'd2);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_LOAD: if (accept && last_particle) state_d = (cnt_next < 2) ? F_END : F_RDA;
			F_RDA:  state_d = F_RDB;
			F_RDB:  state_d = F_PAIR;
			F_PAIR: if (!rec_full) state_d = last_pair ? F_LOAD : F_RDA;
			F_END:  if (!rec_full) state_d = F_LOAD;
			default: state_d = F_LOAD;
		endcase
	end

	// Build the pair record from entry a and the entry read now
	always_comb begin
		dx    = {a_q[31], a_q[31:0]} - {ram_rdata[31], ram_rdata[31:0]};
		dy    = {a_q[63], a_q[63:32]} - {ram_rdata[63], ram_rdata[63:32]};
		dz    = {a_q[95], a_q[95:64]} - {ram_rdata[95], ram_rdata[95:64]};
		rad_a = a_q[126:96];
		rad_b = ram_rdata[126:96];
		rst_a = a_q[142:127];
		rst_b = ram_rdata[142:127];
		i_ext = (IW+3)'(i_q);
		h_ext = (IW+3)'(h_q);
		rec.has_pair = state_q == F_PAIR;
		rec.last     = (state_q == F_END) || last_pair;
		rec.ia       = i_ext[2:0];
		rec.ib       = h_ext[2:0];
		rec.neg_x    = dx[32];
		rec.neg_y    = dy[32];
		rec.neg_z    = dz[32];
		rec.mag_x    = dx[32] ? -dx : dx;
		rec.mag_y    = dy[32] ? -dy : dy;
		rec.mag_z    = dz[32] ? -dz : dz;
		rec.rsum     = {1'b0, rad_a} + {1'b0, rad_b};
		rec.rest     = (rst_a < rst_b) ? rst_a : rst_b;
	end

	assign rec_push = (state_q == F_PAIR || state_q == F_END) && !rec_full;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_LOAD;
			cnt_q   <= '0;
			n_q     <= '0;
			i_q     <= '0;
			h_q     <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= last_particle ? '0 : cnt_next;
				if (last_particle) begin
					n_q <= cnt_next;
					i_q <= '0;
					h_q <= IW'(1);
				end
			end
			// advance to the next pair
			if (state_q == F_PAIR && !rec_full && !last_pair) begin
				if (h_end) begin
					i_q <= i_q + 1'b1;
					h_q <= i_q + IW'(2);
				end else begin
					h_q <= h_q + 1'b1;
				end
			end
		end
	end

	// Hold entry a of the pair
	always_ff @(posedge clk) begin
		if (state_q == F_RDB) a_q <= ram_rdata;
	end

endmodule

>>> src/spoc_back.sv
// Back: per pair, squares, overlap test, two square roots, three divisions,
// and result ordering with the final mark. Depends on spoc_pkg.
module spoc_back import spoc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rec_valid,
	input  pair_rec_t rec,
	output logic      rec_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output contact_t  out_data,
	output logic      out_cv,
	output logic      out_last
);

	back_state_t state_q, state_d;
	pair_rec_t   r_q;
	logic [3:0]  step_q;
	logic [4:0]  it_q;
	logic [1:0]  comp_q;
	logic [CNT_W-1:0] cnt_q;
	logic        done_q, hold_v_q, out_valid_q;
	contact_t    hold_q, cur;
	logic [33:0] prod_s1;
	logic [1:0]  part_s1;
	logic        dst_s1, pv_s1;
	logic [66:0] accd_q, term;
	logic [63:0] accr_q;
	logic [63:0] sq_op_q, sq_res_q, sq_one_q, sq_t, sq_op_n, sq_res_n;
	logic        sq_ge;
	logic [31:0] m_q;
	logic [30:0] dep_q;
	logic [47:0] rem_q, dvs_q;
	logic [14:0] quo_q, quo_n, q_cl;
	logic        div_ge;
	logic [15:0] nx_q, ny_q, nz_q, comp_val;
	logic [32:0] mul_v, mag_init;
	logic [16:0] mul_a, mul_b;
	logic [1:0]  init_comp;
	logic        neg_cur, ovl, lim, sq_last, div_last;
	logic        out_free, take, emit, emit_last, emit_empty;

	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign ovl       = accd_q < {3'b0, accr_q};
	assign lim       = cnt_q + 1'b1 == CNT_W'(RESULT_LIMIT);
	assign sq_last   = it_q == 5'd31;
	assign div_last  = it_q == 5'd14;

	// Select the operand half products for the squaring sequence
	always_comb begin
		case (step_q[3:2])
			2'd0:    mul_v = r_q.mag_x;
			2'd1:    mul_v = r_q.mag_y;
			2'd2:    mul_v = r_q.mag_z;
			default: mul_v = {1'b0, r_q.rsum};
		endcase
		case (step_q[1:0])
			2'd0:    begin mul_a = {1'b0, mul_v[15:0]}; mul_b = {1'b0, mul_v[15:0]}; end
			2'd1:    begin mul_a = mul_v[32:16]; mul_b = {1'b0, mul_v[15:0]}; end
			default: begin mul_a = mul_v[32:16]; mul_b = mul_v[32:16]; end
		endcase
		case (part_s1)
			2'd0:    term = 67'(prod_s1);
			2'd1:    term = 67'(prod_s1) << 17;
			default: term = 67'(prod_s1) << 32;
		endcase
	end

	// One step of the bitwise square root
	always_comb begin
		sq_t     = sq_res_q + sq_one_q;
		sq_ge    = sq_op_q >= sq_t;
		sq_op_n  = sq_ge ? sq_op_q - sq_t : sq_op_q;
		sq_res_n = sq_ge ? (sq_res_q >> 1) + sq_one_q : sq_res_q >> 1;
	end

	// One quotient bit of the normal division, plus operand for the next one
	always_comb begin
		div_ge    = rem_q >= dvs_q;
		quo_n     = {quo_q[13:0], div_ge};
		q_cl      = (m_q == 32'd0) ? 15'd0 : ((quo_n > NORM_ONE) ? NORM_ONE : quo_n);
		case (comp_q)
			2'd0:    neg_cur = r_q.neg_x;
			2'd1:    neg_cur = r_q.neg_y;
			default: neg_cur = r_q.neg_z;
		endcase
		comp_val  = neg_cur ? -{1'b0, q_cl} : {1'b0, q_cl};
		init_comp = (state_q == B_SQD) ? 2'd0 : comp_q + 1'b1;
		case (init_comp)
			2'd0:    mag_init = r_q.mag_x;
			2'd1:    mag_init = r_q.mag_y;
			default: mag_init = r_q.mag_z;
		endcase
	end

	assign cur = '{ia: r_q.ia, ib: r_q.ib, nx: nx_q, ny: ny_q, nz: nz_q,
		depth: dep_q, rest: r_q.rest};

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: if (rec_valid) begin
				if (rec.has_pair && !done_q) state_d = B_MUL;
				else if (rec.last) state_d = B_FIN;
			end
			B_MUL:   if (step_q == 4'd15) state_d = B_CMP;
			B_CMP:   state_d = ovl ? B_SQM : B_NEXT;
			B_SQM:   if (sq_last) state_d = B_SQD;
			B_SQD:   if (sq_last) state_d = B_DIV;
			B_DIV:   if (div_last && comp_q == 2'd2) state_d = B_PUSH;
			B_PUSH:  if (take) state_d = lim ? B_LIMIT : B_NEXT;
			B_LIMIT: if (out_free) state_d = B_NEXT;
			B_NEXT:  state_d = r_q.last ? B_FIN : B_IDLE;
			B_FIN:   if (out_free) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// Output strobes
	always_comb begin
		rec_pop    = 1'b0;
		take       = 1'b0;
		emit       = 1'b0;
		emit_last  = 1'b0;
		emit_empty = 1'b0;
		unique case (state_q)
			B_IDLE:  rec_pop = rec_valid;
			B_PUSH:  begin
				take = !hold_v_q || out_free;
				emit = hold_v_q && out_free;
			end
			B_LIMIT: begin
				emit      = out_free;
				emit_last = 1'b1;
			end
			B_FIN:   begin
				emit       = out_free && (hold_v_q || !done_q);
				emit_last  = 1'b1;
				emit_empty = !hold_v_q;
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			step_q      <= '0;
			it_q        <= '0;
			comp_q      <= '0;
			cnt_q       <= '0;
			done_q      <= 1'b0;
			hold_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
			pv_s1       <= 1'b0;
		end else begin
			state_q <= state_d;
			pv_s1   <= state_q == B_MUL && step_q[1:0] != 2'd3;
			step_q  <= (state_q == B_MUL) ? step_q + 1'b1 : '0;
			if (state_q == B_SQM || state_q == B_SQD) begin
				it_q <= sq_last ? '0 : it_q + 1'b1;
			end else if (state_q == B_DIV) begin
				it_q <= div_last ? '0 : it_q + 1'b1;
			end else begin
				it_q <= '0;
			end
			if (state_q == B_SQD) comp_q <= 2'd0;
			else if (state_q == B_DIV && div_last) comp_q <= comp_q + 1'b1;
			// count contacts and track the pending one
			if (take) begin
				cnt_q    <= cnt_q + 1'b1;
				hold_v_q <= 1'b1;
			end
			if (state_q == B_LIMIT && out_free) begin
				hold_v_q <= 1'b0;
				done_q   <= 1'b1;
			end
			if (state_q == B_FIN && out_free) begin
				hold_v_q <= 1'b0;
				done_q   <= 1'b0;
				cnt_q    <= '0;
			end
			if (emit) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (rec_pop) r_q <= rec;
		prod_s1 <= mul_a * mul_b;
		part_s1 <= step_q[1:0];
		dst_s1  <= step_q[3:2] == 2'd3;
		// accumulate squared distance and squared radius sum
		if (state_q == B_IDLE) begin
			accd_q <= '0;
			accr_q <= '0;
		end else if (pv_s1) begin
			if (dst_s1) accr_q <= accr_q + term[63:0];
			else accd_q <= accd_q + term;
		end
		// square roots: centre distance, then depth
		if (state_q == B_CMP) begin
			sq_op_q  <= accd_q[63:0];
			sq_res_q <= '0;
			sq_one_q <= 64'd1 << 62;
		end else if (state_q == B_SQM && sq_last) begin
			m_q      <= sq_res_n[31:0];
			sq_op_q  <= accr_q - accd_q[63:0];
			sq_res_q <= '0;
			sq_one_q <= 64'd1 << 62;
		end else begin
			sq_op_q  <= sq_op_n;
			sq_res_q <= sq_res_n;
			sq_one_q <= sq_one_q >> 2;
		end
		if (state_q == B_SQD && sq_last) begin
			dep_q <= (sq_res_n[63:31] != '0) ? 31'h7FFF_FFFF : sq_res_n[30:0];
		end
		// normal components: load a division or take one quotient bit
		if ((state_q == B_SQD && sq_last) || (state_q == B_DIV && div_last)) begin
			rem_q <= 48'({mag_init, 14'b0}) + 48'(m_q[31:1]);
			dvs_q <= 48'({m_q, 14'b0});
			quo_q <= '0;
		end else begin
			if (div_ge) rem_q <= rem_q - dvs_q;
			dvs_q <= dvs_q >> 1;
			quo_q <= quo_n;
		end
		if (state_q == B_DIV && div_last) begin
			case (comp_q)
				2'd0:    nx_q <= comp_val;
				2'd1:    ny_q <= comp_val;
				default: nz_q <= comp_val;
			endcase
		end
		if (take) hold_q <= cur;
		if (emit) begin
			out_data <= emit_empty ? '0 : hold_q;
			out_cv   <= !emit_empty;
			out_last <= emit_last;
		end
	end

endmodule

>>> src/sphere_pair_overlap_contacts_unit.sv
// Loads are taken while in_stall is low; the last load starts a walk over all pairs i<h.
// The front reads each pair in states F_RDA, F_RDB and F_PAIR. The back squares and sums
// the terms of each pair, and when it overlaps runs 32+32 square root steps, 3x15 division steps and one push.
// A contact is held until the next one is pushed or the set ends; input is held off until
// the final pair is queued.
// arst_n clears all control state; the sphere store needs no clearing.
`include "sphere_pair_overlap_contacts_unit_assert.svh"
module sphere_pair_overlap_contacts_unit import spoc_pkg::*; #(
	parameter int MAX_PARTICLES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic [31:0] pos_z,
	input  logic [30:0] sphere_radius,
	input  logic [15:0] particle_restitution,
	input  logic        last_particle,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  first_index,
	output logic [2:0]  second_index,
	output logic [15:0] normal_x,
	output logic [15:0] normal_y,
	output logic [15:0] normal_z,
	output logic [30:0] overlap_depth,
	output logic [15:0] contact_restitution,
	output logic        contact_valid,
	output logic        last_contact
);

	localparam int IW = $clog2(MAX_PARTICLES);

	logic              ram_we;
	logic [IW-1:0]     ram_waddr, ram_raddr;
	logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic              fifo_push, fifo_full, fifo_pop, fifo_empty;
	pair_rec_t         fifo_din, fifo_dout;
	contact_t          res;

	spoc_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PARTICLES)) u_store (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
		.raddr(ram_raddr), .rdata(ram_rdata)
	);

	spoc_front #(.MAX_PARTICLES(MAX_PARTICLES)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .sphere_radius(sphere_radius),
		.particle_restitution(particle_restitution), .last_particle(last_particle),
		.ram_we(ram_we), .ram_waddr(ram_waddr), .ram_wdata(ram_wdata),
		.ram_raddr(ram_raddr), .ram_rdata(ram_rdata),
		.rec_push(fifo_push), .rec(fifo_din), .rec_full(fifo_full)
	);

	spoc_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(fifo_push), .din(fifo_din), .full(fifo_full),
		.pop(fifo_pop), .dout(fifo_dout), .empty(fifo_empty)
	);

	spoc_back u_back (
		.clk(clk), .arst_n(arst_n), .rec_valid(!fifo_empty), .rec(fifo_dout),
		.rec_pop(fifo_pop), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(res), .out_cv(contact_valid), .out_last(last_contact)
	);

	assign first_index         = res.ia;
	assign second_index        = res.ib;
	assign normal_x            = res.nx;
	assign normal_y            = res.ny;
	assign normal_z            = res.nz;
	assign overlap_depth       = res.depth;
	assign contact_restitution = res.rest;

	// Queue never written while full unless it is also popped, empty report always closes a set
	`SPOC_ASSERT(a_fifo_no_overflow, !(fifo_push && fifo_full && !fifo_pop), "pair queue overflow")
	`SPOC_ASSERT_IMP(a_empty_is_last, out_valid && !contact_valid, last_contact, "empty report not last")
	`SPOC_ASSERT_IMP(a_empty_zero, out_valid && !contact_valid, overlap_depth == 31'd0 && contact_restitution == 16'd0, "empty report carries data")

endmodule

>>> verif/sphere_pair_overlap_contacts_unit_tb.sv
// Self-checking testbench of the sphere pair overlap contacts unit.
// Depends on spoc_pkg and the unit's top level; contacts are predicted per set.
`timescale 1ns / 1ps
module sphere_pair_overlap_contacts_unit_tb;
	import spoc_pkg::*;

	localparam int SPHERE_CAP  = 8;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [2:0]  ia;
		logic [2:0]  ib;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
		logic [30:0] depth;
		logic [15:0] rest;
		logic        cvalid;
		logic        clast;
	} contact_exp_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] pos_x;
	logic [31:0] pos_y;
	logic [31:0] pos_z;
	logic [30:0] sphere_radius;
	logic [15:0] particle_restitution;
	logic        last_particle;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  first_index;
	logic [2:0]  second_index;
	logic [15:0] normal_x;
	logic [15:0] normal_y;
	logic [15:0] normal_z;
	logic [30:0] overlap_depth;
	logic [15:0] contact_restitution;
	logic        contact_valid;
	logic        last_contact;

	// Predictor state: copy of the sphere store
	logic signed [32:0] sx [SPHERE_CAP];
	logic signed [32:0] sy [SPHERE_CAP];
	logic signed [32:0] sz [SPHERE_CAP];
	logic [31:0]        srad [SPHERE_CAP];
	logic [15:0]        srest [SPHERE_CAP];
	int                 stored_count;

	contact_exp_t pending_contacts[$];
	int  error_count;
	int  cycle_count;
	int  stall_mode;
	bit  burst_idle;

	sphere_pair_overlap_contacts_unit DUT (.*);

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sphere_pair_overlap_contacts_unit test failed");
			$finish;
		end
	end

	function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] op, res, one;
		op = v;
		res = 0;
		one = 64'd1 << 62;
		while (one > op) one = one >> 2;
		while (one != 0) begin
			if (op >= res + one) begin
				op = op - (res + one);
				res = (res >> 1) + one;
			end else begin
				res = res >> 1;
			end
			one = one >> 2;
		end
		return res;
	endfunction

	function automatic logic [15:0] unit_component(logic signed [32:0] d, logic [63:0] m);
		logic [63:0] mag, q;
		if (m == 0) return 16'd0;
		mag = d < 0 ? 64'(-d) : 64'(d);
		q = ((mag << 14) + (m >> 1)) / m;
		if (q > 16384) q = 16384;
		if (d < 0) q = -q;
		return q[15:0];
	endfunction

	// Store a sphere and, on the last mark, queue the contacts of the set
	task automatic predict_contacts(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [30:0] r, logic [15:0] e, logic lst);
		int count;
		logic signed [32:0] dx, dy, dz;
		logic [65:0] dist2;
		logic [63:0] r2, m, dep;
		logic [31:0] rs;
		contact_exp_t c;
		if (stored_count < SPHERE_CAP) begin
			sx[stored_count] = 33'(signed'(px));
			sy[stored_count] = 33'(signed'(py));
			sz[stored_count] = 33'(signed'(pz));
			srad[stored_count] = {1'b0, r};
			srest[stored_count] = e;
			stored_count++;
		end
		if (!lst) return;
		count = 0;
		for (int i = 0; i + 1 < stored_count && count < RESULT_LIMIT; i++) begin
			for (int h = i + 1; h < stored_count && count < RESULT_LIMIT; h++) begin
				dx = sx[i] - sx[h];
				dy = sy[i] - sy[h];
				dz = sz[i] - sz[h];
				dist2 = 66'(dx * dx) + 66'(dy * dy) + 66'(dz * dz);
				rs = srad[i] + srad[h];
				r2 = 64'(rs) * 64'(rs);
				if (dist2 >= 66'(r2)) continue;
				m = int_sqrt(dist2[63:0]);
				dep = int_sqrt(r2 - dist2[63:0]);
				if (dep > 64'h7FFFFFFF) dep = 64'h7FFFFFFF;
				c.ia = 3'(i);
				c.ib = 3'(h);
				c.nx = unit_component(dx, m);
				c.ny = unit_component(dy, m);
				c.nz = unit_component(dz, m);
				c.depth = dep[30:0];
				c.rest = srest[i] < srest[h] ? srest[i] : srest[h];
				c.cvalid = 1'b1;
				c.clast = 1'b0;
				pending_contacts = {pending_contacts, c};
				count++;
			end
		end
		if (count == 0) begin
			c = '{default: '0};
			pending_contacts = {pending_contacts, c};
		end
		pending_contacts[pending_contacts.size() - 1].clast = 1'b1;
		stored_count = 0;
	endtask

	// Check each transfer of a result against the oldest expectation
	always @(posedge clk) begin
		contact_exp_t x;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_contacts.size() == 0) begin
				$display("%0t: expected none, actual result %0d/%0d", $time,
					first_index, second_index);
				error_count++;
			end else begin
				x = pending_contacts.pop_front();
				if ({first_index, second_index, normal_x, normal_y, normal_z, overlap_depth,
						contact_restitution, contact_valid, last_contact} !==
						{x.ia, x.ib, x.nx, x.ny, x.nz, x.depth, x.rest, x.cvalid, x.clast}) begin
					$display("%0t: expected ia=%0d ib=%0d n=%h,%h,%h d=%h r=%h v=%b l=%b", $time,
						x.ia, x.ib, x.nx, x.ny, x.nz, x.depth, x.rest, x.cvalid, x.clast);
					$display("%0t: actual   ia=%0d ib=%0d n=%h,%h,%h d=%h r=%h v=%b l=%b", $time,
						first_index, second_index, normal_x, normal_y, normal_z,
						overlap_depth, contact_restitution, contact_valid, last_contact);
					error_count++;
				end
			end
		end
	end

	// Stall the result side on a pattern set by the current mode
	always @(negedge clk) begin
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 1) == 0);
		endcase
		if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
	end

	// Send one sphere; hold the payload until the transfer
	task automatic send_sphere(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
			logic [30:0] r, logic [15:0] e, logic lst);
		@(negedge clk);
		if (burst_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		if ($urandom_range(0, 9) == 0) burst_idle = ~burst_idle;
		in_valid <= 1'b1;
		pos_x <= px;
		pos_y <= py;
		pos_z <= pz;
		sphere_radius <= r;
		particle_restitution <= e;
		last_particle <= lst;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_contacts(px, py, pz, r, e, lst);
	endtask

	// Drop valid and wait until every expected result has come
	task automatic wait_drained;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_contacts.size() != 0) @(negedge clk);
	endtask

	task automatic test_extremes;
		send_sphere(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 16'd32768, 1'b0);
		send_sphere(32'h80000000, 32'h80000000, 32'h80000000, 31'h7FFFFFFF, 16'hFFFF, 1'b1);
		send_sphere(0, 0, 0, 0, 0, 1'b1);
		send_sphere(32'h10000, 0, 0, 31'h10000, 16'd100, 1'b1);
		send_sphere(0, 0, 0, 31'h20000, 16'd200, 1'b0);
		send_sphere(0, 0, 0, 31'h10000, 16'd100, 1'b1);
		send_sphere(0, 0, 0, 31'h10000, 0, 1'b0);
		send_sphere(32'h20000, 0, 0, 31'h10000, 0, 1'b1);
	endtask

	// Overfill the store so loads get dropped and every pair overlaps
	task automatic test_full_store;
		for (int k = 0; k < 11; k++)
			send_sphere($urandom_range(0, 255), $urandom_range(0, 255),
				$urandom_range(0, 255), 31'h40000, 16'($urandom), k == 10);
	endtask

	task automatic test_random_sets;
		int items, n, spread;
		logic [31:0] base;
		items = 0;
		while (items < 300) begin
			n = $urandom_range(1, 10);
			spread = $urandom_range(0, 3);
			base = $urandom;
			for (int k = 0; k < n; k++) begin
				case (spread)
					0: send_sphere($urandom, $urandom, $urandom, 31'($urandom),
						16'($urandom), k == n - 1);
					1: send_sphere(base + $urandom_range(0, 32'h80000),
						base - $urandom_range(0, 32'h80000), $urandom_range(0, 32'h80000),
						31'($urandom_range(0, 32'h60000)), 16'($urandom_range(0, 32768)),
						k == n - 1);
					default: send_sphere(base ^ $urandom_range(0, 32'h3FFFFF),
						$urandom_range(0, 32'h3FFFFF), -$urandom_range(0, 32'h3FFFFF),
						31'($urandom_range(0, 32'h400000)), 16'($urandom_range(0, 32768)),
						k == n - 1);
				endcase
				items++;
			end
			if ($urandom_range(0, 15) == 0) wait_drained;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		sphere_radius = '0;
		particle_restitution = '0;
		last_particle = 1'b0;
		stored_count = 0;
		error_count = 0;
		cycle_count = 0;
		stall_mode = 0;
		burst_idle = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		test_extremes;
		wait_drained;
		test_full_store;
		test_random_sets;
		wait_drained;
		repeat (400) @(negedge clk);
		if (error_count == 0 && pending_contacts.size() == 0) begin
			$display("sphere_pair_overlap_contacts_unit test passed");
		end else begin
			$display("sphere_pair_overlap_contacts_unit test failed");
		end
		$finish;
	end

endmodule
